// File: design/ftkr_pkg.sv
// ============================================================================
// ftkr_pkg
// Shared types and constants for the filtered top-k ranker.
// ============================================================================
package ftkr_pkg;

    localparam int LIST_DEPTH    = 128;
    localparam int KEY_W         = 32;
    localparam int TAG_W         = 16;
    localparam int CNT_W         = 32;
    localparam int POS_W         = 7;
    localparam int TYPE_W        = 8;
    localparam int NLEN_W        = 4;
    localparam int LEVEL_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam int RD_LO_W       = 4;
    localparam int RD_GRP_SIZE   = 1 << RD_LO_W;
    localparam int RD_HI_W       = POS_W - RD_LO_W;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_STAFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STAFF_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZERO_KEY  = 2'd2;

    localparam logic [TYPE_W-1:0] STAFF_THRESH_RESET = 8'd14;
    localparam logic [TYPE_W-1:0] MIN_TYPE           = 8'd1;
    localparam logic [NLEN_W-1:0] MIN_NAME_LEN       = 4'd3;
    localparam logic [CNT_W-1:0]  CNT_MAX            = '1;

    typedef struct packed {
        logic [1:0]                func;
        logic [KEY_W-1:0]          rank_key;
        logic [TAG_W-1:0]          record_tag;
        logic [TYPE_W-1:0]         member_type;
        logic [NLEN_W-1:0]         name_length;
        logic signed [LEVEL_W-1:0] member_level;
        logic [POS_W-1:0]          read_position;
    } in_t;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic [CNT_W-1:0] accepted_total;
        logic             was_ranked;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // link between neighboring cells
    typedef struct packed {
        entry_t entry;
        logic   shift;
    } link_t;

endpackage

// File: design/filtered_top_k_ranker_top.sv
// ============================================================================
// filtered_top_k_ranker_top
// Filtered top-k ranked list built as a row of compare-and-shift cells.
// ============================================================================
// Clear, insert and unused-code transactions: every cell compares against
// the new key at once and the whole row shifts together, so the result is
// registered on the accepting edge. A read passes through the two-level
// position select over the cell row, whose first level is registered;
// while the read is busy, no new transaction is taken. A result held in the
// output register under out_stall holds off the next transaction until the
// result is taken.
// ============================================================================
module filtered_top_k_ranker_top
#(
    parameter int LIST_DEPTH = ftkr_pkg::LIST_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ftkr_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ftkr_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [ftkr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftkr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                            exclude_staff_reg;
    logic [ftkr_pkg::TYPE_W-1:0]     staff_thresh_reg;
    logic                            skip_zero_key_reg;

    logic [ftkr_pkg::CNT_W-1:0]      count_reg;
    logic [ftkr_pkg::CNT_W-1:0]      count_next;
    logic                            rd_busy_reg;
    logic                            rd_busy_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    ftkr_pkg::out_t                  out_data_reg;
    ftkr_pkg::out_t                  out_data_next;

    logic                            in_accept;
    logic                            is_clear;
    logic                            is_insert;
    logic                            is_read;
    logic                            rec_valid;
    logic                            ins_en;
    logic                            was_ranked;

    ftkr_pkg::entry_t                new_entry;
    ftkr_pkg::link_t                 links   [LIST_DEPTH+1];
    ftkr_pkg::entry_t                entries [LIST_DEPTH];
    ftkr_pkg::entry_t                rd_entry;

    assign in_stall  = rd_busy_reg | (out_valid_reg & out_stall);
    assign in_accept = in_valid & ~in_stall;
    assign is_clear  = in_accept && (in_data.func == ftkr_pkg::FUNC_CLEAR);
    assign is_insert = in_accept && (in_data.func == ftkr_pkg::FUNC_INSERT);
    assign is_read   = in_accept && (in_data.func == ftkr_pkg::FUNC_READ);

    assign rec_valid = (in_data.member_type >= ftkr_pkg::MIN_TYPE)
                    && (in_data.name_length >= ftkr_pkg::MIN_NAME_LEN)
                    && (in_data.member_level > 16'sd0)
                    && !(exclude_staff_reg && (in_data.member_type >= staff_thresh_reg));

    assign ins_en = is_insert && rec_valid
                 && !(skip_zero_key_reg && (in_data.rank_key == '0));

    assign new_entry.key = in_data.rank_key;
    assign new_entry.tag = in_data.record_tag;

    // cell row
    assign links[0] = '0;
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        ftkr_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .clr       (is_clear),
            .ins       (ins_en),
            .new_entry (new_entry),
            .prev      (links[i]),
            .link      (links[i+1])
        );
        assign entries[i] = links[i+1].entry;
    end

    assign was_ranked = ins_en && links[LIST_DEPTH].shift;

    ftkr_read_sel #(.LIST_DEPTH(LIST_DEPTH)) u_read_sel
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (is_read),
        .rpos     (in_data.read_position),
        .entries  (entries),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        count_next = count_reg;
        if (is_clear)
        begin
            count_next = '0;
        end
        else if (is_insert && rec_valid && (count_reg != ftkr_pkg::CNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_busy_next   = rd_busy_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (rd_busy_reg)
        begin
            rd_busy_next                 = 1'b0;
            out_valid_next               = 1'b1;
            out_data_next.out_key        = rd_entry.key;
            out_data_next.out_tag        = rd_entry.tag;
            out_data_next.accepted_total = count_reg;
            out_data_next.was_ranked     = 1'b0;
        end
        else if (is_read)
        begin
            rd_busy_next = 1'b1;
        end
        else if (in_accept)
        begin
            out_valid_next               = 1'b1;
            out_data_next.out_key        = '0;
            out_data_next.out_tag        = '0;
            out_data_next.accepted_total = count_next;
            out_data_next.was_ranked     = was_ranked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_busy_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_busy_reg   <= rd_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exclude_staff_reg <= 1'b0;
            staff_thresh_reg  <= ftkr_pkg::STAFF_THRESH_RESET;
            skip_zero_key_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ftkr_pkg::REG_EXCLUDE_STAFF: exclude_staff_reg <= cfg_data[0];
                ftkr_pkg::REG_STAFF_THRESH:  staff_thresh_reg  <= cfg_data;
                ftkr_pkg::REG_SKIP_ZERO_KEY: skip_zero_key_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/ftkr_cell.sv
// ============================================================================
// ftkr_cell
// One slot of the ranked list: holds a key and tag, takes the new record or
// the upper neighbor's entry on an insert, and is zeroed on a clear.
// ============================================================================
module ftkr_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clr,
    input  logic            ins,
    input  ftkr_pkg::entry_t new_entry,
    input  ftkr_pkg::link_t  prev,
    output ftkr_pkg::link_t  link
);

    ftkr_pkg::entry_t entry_reg;
    ftkr_pkg::entry_t entry_next;
    logic             le;

    assign le = (entry_reg.key <= new_entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        if (clr)
        begin
            entry_next = '0;
        end
        else if (ins)
        begin
            if (prev.shift)
            begin
                entry_next = prev.entry;
            end
            else if (le)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign link.entry = entry_reg;
    assign link.shift = le;

endmodule

// File: design/ftkr_read_sel.sv
// ============================================================================
// ftkr_read_sel
// Position select over the cell row: first level picks within groups of
// sixteen and is registered, second level picks the group.
// ============================================================================
module ftkr_read_sel
#(
    parameter int LIST_DEPTH = ftkr_pkg::LIST_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ftkr_pkg::POS_W-1:0]     rpos,
    input  ftkr_pkg::entry_t               entries [LIST_DEPTH],
    output ftkr_pkg::entry_t               rd_entry
);

    localparam int NUM_GRP   = (LIST_DEPTH + ftkr_pkg::RD_GRP_SIZE - 1) / ftkr_pkg::RD_GRP_SIZE;
    localparam int MAX_GRP   = 1 << ftkr_pkg::RD_HI_W;
    localparam int RD_GROUPS = (NUM_GRP < MAX_GRP) ? NUM_GRP : MAX_GRP;

    ftkr_pkg::entry_t                  grp_reg  [RD_GROUPS];
    ftkr_pkg::entry_t                  grp_next [RD_GROUPS];
    logic [ftkr_pkg::RD_HI_W-1:0]      sel_reg;
    logic                              in_range_reg;
    logic                              in_range;

    assign in_range = (32'(rpos) < 32'(LIST_DEPTH));

    for (genvar g = 0; g < RD_GROUPS; g++)
    begin : g_grp
        ftkr_pkg::entry_t cand [ftkr_pkg::RD_GRP_SIZE];
        for (genvar j = 0; j < ftkr_pkg::RD_GRP_SIZE; j++)
        begin : g_cand
            if (g * ftkr_pkg::RD_GRP_SIZE + j < LIST_DEPTH)
            begin : g_on
                assign cand[j] = entries[g * ftkr_pkg::RD_GRP_SIZE + j];
            end
            else
            begin : g_off
                assign cand[j] = '0;
            end
        end
        assign grp_next[g] = cand[rpos[ftkr_pkg::RD_LO_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            grp_reg <= grp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= '0;
            in_range_reg <= 1'b0;
        end
        else if (start)
        begin
            sel_reg      <= rpos[ftkr_pkg::POS_W-1:ftkr_pkg::RD_LO_W];
            in_range_reg <= in_range;
        end
    end

    always_comb
    begin
        rd_entry = '0;
        for (int g = 0; g < RD_GROUPS; g++)
        begin
            if (in_range_reg && sel_reg == ftkr_pkg::RD_HI_W'(g))
            begin
                rd_entry = grp_reg[g];
            end
        end
    end

endmodule
